// ----- rtl/osnd_pkg.sv -----
// osnd_pkg: shared types and constants for the ordered-set nearest-distance block.
// No dependencies.
package osnd_pkg;

    localparam int CAPACITY = 64;
    localparam int LG       = $clog2(CAPACITY);
    localparam int CAP_P2   = 1 << LG;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int STEP_W   = $clog2(LG + 1);
    localparam int KEY_W    = 32;
    localparam int DIST_W   = 31;

    localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_DUP    = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [KEY_W-1:0] key_value;
    } t_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              set_empty;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic                    load;
        logic                    take;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] value;
    } t_cell_data;

endpackage

// ----- rtl/osnd_cell.sv -----
// osnd_cell: one table cell; holds a key and valid bit, compares against the broadcast key.
// Depends on osnd_pkg.
module osnd_cell import osnd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  t_cell_data        i_nb,
    output t_cell_data        o_data,
    output logic              o_match,
    output logic [DIST_W-1:0] o_dist
);

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_value;
    logic signed [KEY_W:0]   diff;
    logic [KEY_W:0]          mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_ctl.take) begin
            r_valid <= i_nb.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= i_ctl.key;
        end else if (i_ctl.take) begin
            r_value <= i_nb.value;
        end
    end

    always_comb begin
        diff = {i_ctl.key[KEY_W-1], i_ctl.key} - {r_value[KEY_W-1], r_value};
        mag  = diff[KEY_W] ? (KEY_W+1)'(1) + (KEY_W+1)'(~diff) : diff;
        if (!r_valid || (|mag[KEY_W:DIST_W])) begin
            o_dist = DIST_MAX;
        end else begin
            o_dist = mag[DIST_W-1:0];
        end
    end

    assign o_match      = r_valid && (r_value == i_ctl.key);
    assign o_data.valid = r_valid;
    assign o_data.value = r_value;

endmodule

// ----- rtl/osnd_min_tree.sv -----
// osnd_min_tree: folds the cell distances pairwise, one tree level per cycle while i_step is high.
// Depends on osnd_pkg.
module osnd_min_tree import osnd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_step,
    input  logic [DIST_W-1:0] i_leaf [CAPACITY],
    output logic [DIST_W-1:0] o_min
);

    logic [DIST_W-1:0] r_min [CAP_P2];

    for (genvar g = 0; g < CAP_P2; g++) begin : g_slot
        logic [DIST_W-1:0] leaf;
        logic [DIST_W-1:0] fold;

        if (g < CAPACITY) begin : g_leaf
            assign leaf = i_leaf[g];
        end else begin : g_pad
            assign leaf = DIST_MAX;
        end

        if (g < CAP_P2 / 2) begin : g_fold
            assign fold = (r_min[2*g] < r_min[2*g+1]) ? r_min[2*g] : r_min[2*g+1];
        end else begin : g_keep
            assign fold = r_min[g];
        end

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_min[g] <= leaf;
            end else if (i_step) begin
                r_min[g] <= fold;
            end
        end
    end

    assign o_min = (r_min[0] < r_min[1]) ? r_min[0] : r_min[1];

endmodule

// ----- rtl/ordered_set_nearest_distance.sv -----
// ordered_set_nearest_distance: top level; sequencer around a compacted row of key cells.
// Depends on osnd_pkg, osnd_cell, osnd_min_tree.
//
// Usage: a request (cmd, key_value) transfers at a rising edge with start high and
// busy low. One result per request appears on o_result for a single cycle with
// o_done high; the receiver cannot stall it, so it must be taken then.
// Valid keys are packed at the low cells; the entry count points at the next free cell.
// Steps from the accepting edge to the o_done cycle:
//   insert, and remove of an absent key: match, then result
//   remove of a present key: match, then shift the cells above down by one, then result
//   query: match, then the pairwise minimum tree takes one level per cycle.
// busy is low during the o_done cycle, so the next request may transfer at the edge
// that ends it; a new request is not taken before the last one's result is shown.
// Reset (synchronous, active low) empties the set and drops any request in flight.
module ordered_set_nearest_distance import osnd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY,
        S_REDUCE
    } t_state;

    t_state                  r_state;
    logic [1:0]              r_cmd;
    logic signed [KEY_W-1:0] r_key;
    logic [COUNT_W-1:0]      r_count;
    logic [CAPACITY-1:0]     r_hit;
    logic [STEP_W-1:0]       r_steps;
    logic                    r_empty;
    logic                    r_done;
    t_result                 r_result;

    t_cell_ctl               ctl       [CAPACITY];
    t_cell_data              data      [CAPACITY];
    t_cell_data              nb        [CAPACITY];
    logic [DIST_W-1:0]       cell_dist [CAPACITY];
    logic [CAPACITY-1:0]     match;
    logic [CAPACITY-1:0]     shift_en;
    logic                    any_hit;
    logic                    full;
    logic                    ins_ok;
    logic                    is_query;
    logic                    tree_load;
    logic                    tree_step;
    logic [DIST_W-1:0]       tree_min;

    assign any_hit   = |match;
    assign full      = (r_count >= COUNT_W'(CAPACITY));
    assign is_query  = (r_cmd != CMD_INSERT) && (r_cmd != CMD_REMOVE);
    assign ins_ok    = (r_state == S_MATCH) && (r_cmd == CMD_INSERT) && !any_hit && !full;
    assign tree_load = (r_state == S_MATCH) && is_query;
    assign tree_step = (r_state == S_REDUCE) && (r_steps != '0);
    // one-hot hit: every cell at or above it pulls from its upper neighbor
    assign shift_en  = ~(r_hit - CAPACITY'(1));

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign ctl[g].key  = r_key;
        assign ctl[g].load = ins_ok && (r_count == COUNT_W'(g));
        assign ctl[g].take = (r_state == S_APPLY) && shift_en[g];

        if (g == CAPACITY - 1) begin : g_end
            assign nb[g] = '0;
        end else begin : g_link
            assign nb[g] = data[g+1];
        end

        osnd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[g]),
            .i_nb    (nb[g]),
            .o_data  (data[g]),
            .o_match (match[g]),
            .o_dist  (cell_dist[g])
        );
    end

    osnd_min_tree u_tree (
        .i_clk  (i_clk),
        .i_load (tree_load),
        .i_step (tree_step),
        .i_leaf (cell_dist),
        .o_min  (tree_min)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_item.cmd;
                        r_key   <= i_item.key_value;
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    if (r_cmd == CMD_INSERT) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (any_hit) begin
                            r_result <= '{distance: '0, set_empty: 1'b0, status: ST_DUP};
                        end else if (full) begin
                            r_result <= '{distance: '0, set_empty: 1'b0, status: ST_FULL};
                        end else begin
                            r_result <= '{distance: '0, set_empty: 1'b0, status: ST_DONE};
                            r_count  <= r_count + COUNT_W'(1);
                        end
                    end else if (r_cmd == CMD_REMOVE) begin
                        if (any_hit) begin
                            r_result <= '{distance: '0, set_empty: 1'b0, status: ST_DONE};
                            r_hit    <= match;
                            r_state  <= S_APPLY;
                        end else begin
                            r_result <= '{distance: '0, set_empty: 1'b0, status: ST_ABSENT};
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_result <= '{distance: '0, set_empty: 1'b0, status: ST_DONE};
                        r_empty  <= (r_count == '0);
                        r_steps  <= STEP_W'(LG - 1);
                        r_state  <= S_REDUCE;
                    end
                end
                S_APPLY: begin
                    r_count <= r_count - COUNT_W'(1);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_REDUCE: begin
                    if (r_steps == '0) begin
                        r_result.distance  <= tree_min;
                        r_result.set_empty <= r_empty;
                        r_done             <= 1'b1;
                        r_state            <= S_IDLE;
                    end else begin
                        r_steps <= r_steps - STEP_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- rtl/osnd_checker.sv -----
// osnd_checker: port-level assertions for ordered_set_nearest_distance, with its bind.
// Depends on osnd_pkg.
module osnd_checker import osnd_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    a_empty_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.set_empty |-> o_result.distance == DIST_MAX)
        else $error("empty set must report saturated distance");

    a_status_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status != ST_DONE) |->
            (o_result.distance == '0) && !o_result.set_empty)
        else $error("non-query status with query fields set");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_done)
        else $error("transfer not followed by busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_done)
        else $error("reset did not clear the block");

endmodule

bind ordered_set_nearest_distance osnd_checker u_osnd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench for ordered_set_nearest_distance; predicts each result from
// a key-set shadow and compares every strobed result in order. Depends on osnd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import osnd_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         POOL_SIZE   = 96;
    localparam int         RANDOM_ITEMS = 1000;

    typedef enum int {PH_MIXED, PH_FILL, PH_DRAIN} t_phase;

    typedef struct {
        t_item item;
        int    gap_after;
        bit    drain_first;
    } t_request;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_item   i_item = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    t_request                pending_requests[$];
    t_result                 expected_results[$];
    logic signed [KEY_W-1:0] stored_keys[$];
    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];
    int                      idle_left = 0;
    int                      error_count = 0;
    int                      cycle_count = 0;

    ordered_set_nearest_distance u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the key set: applies one request and returns its result.
    function automatic t_result apply_request(t_item req);
        t_result res;
        int      hit;
        longint  gap;
        longint  best;
        res = '0;
        hit = -1;
        foreach (stored_keys[i]) begin
            if (stored_keys[i] == req.key_value) hit = i;
        end
        case (req.cmd)
            CMD_INSERT: begin
                if (hit >= 0) res.status = ST_DUP;
                else if (stored_keys.size() >= CAPACITY) res.status = ST_FULL;
                else stored_keys.push_back(req.key_value);
            end
            CMD_REMOVE: begin
                if (hit < 0) res.status = ST_ABSENT;
                else stored_keys.delete(hit);
            end
            default: begin
                best = longint'(DIST_MAX);
                foreach (stored_keys[i]) begin
                    gap = longint'($signed(stored_keys[i])) - longint'($signed(req.key_value));
                    if (gap < 0) gap = -gap;
                    if (gap < best) best = gap;
                end
                res.distance  = best[DIST_W-1:0];
                res.set_empty = (stored_keys.size() == 0);
            end
        endcase
        return res;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [KEY_W-1:0] pick_query_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)] + $urandom_range(0, 2000)
                           - 1000;
        return $urandom;
    endfunction

    task automatic add_request(logic [1:0] cmd, logic [KEY_W-1:0] key, int gap, bit drain);
        t_request req;
        req.item.cmd       = cmd;
        req.item.key_value = key;
        req.gap_after      = gap;
        req.drain_first    = drain;
        pending_requests.push_back(req);
    endtask

    // Request driver: one transfer per start && !busy edge.
    always @(posedge i_clk) begin : drive_requests
        t_request req;
        logic     next_start;
        t_item    next_item;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            next_start = start;
            next_item  = i_item;
            if (start && !busy) begin
                expected_results.push_back(apply_request(i_item));
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (pending_requests.size() > 0 &&
                             !(pending_requests[0].drain_first &&
                               expected_results.size() > 0)) begin
                    req        = pending_requests.pop_front();
                    next_item  = req.item;
                    next_start = 1'b1;
                    idle_left  = req.gap_after;
                end
            end
            start  <= next_start;
            i_item <= next_item;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: distance %0d set_empty %0b status %0d",
                       o_result.distance, o_result.set_empty, o_result.status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.distance !== want.distance) begin
                    $error("distance: expected %0d, actual %0d", want.distance,
                           o_result.distance);
                    error_count++;
                end
                if (o_result.set_empty !== want.set_empty) begin
                    $error("set_empty: expected %0b, actual %0b", want.set_empty,
                           o_result.set_empty);
                    error_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_result.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_phase     kind;
        int         phase_len;
        int         random_count;
        int         r;
        bit         calm;
        bit         drain;
        logic [1:0] cmd;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        key_pool[5] = 32'h8000_0001;
        key_pool[6] = 32'h7FFF_FFFE;
        for (int i = 7; i < POOL_SIZE; i++) begin
            key_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 4000) - 2000;
        end

        // Directed: empty set, duplicates, absent removes, extremes and saturation.
        add_request(CMD_QUERY,   32'h0000_0000, 0, 1'b0);
        add_request(CMD_UNUSED,  32'h8000_0000, 1, 1'b0);
        add_request(CMD_REMOVE,  32'h0000_0005, 0, 1'b0);
        add_request(CMD_INSERT,  32'h8000_0000, 0, 1'b0);
        add_request(CMD_INSERT,  32'h8000_0000, 2, 1'b0);
        add_request(CMD_QUERY,   32'h7FFF_FFFF, 0, 1'b0);
        add_request(CMD_QUERY,   32'h8000_0000, 0, 1'b0);
        add_request(CMD_INSERT,  32'h7FFF_FFFF, 0, 1'b0);
        add_request(CMD_QUERY,   32'h0000_0000, 0, 1'b0);
        add_request(CMD_QUERY,   32'hFFFF_FFFF, 3, 1'b0);
        add_request(CMD_QUERY,   32'h0000_0001, 0, 1'b0);
        add_request(CMD_INSERT,  32'h0000_0000, 0, 1'b0);
        add_request(CMD_QUERY,   32'hFFFF_FFFB, 0, 1'b0);
        add_request(CMD_UNUSED,  32'h0000_0007, 0, 1'b0);
        add_request(CMD_REMOVE,  32'h8000_0000, 0, 1'b0);
        add_request(CMD_REMOVE,  32'h8000_0000, 0, 1'b0);
        add_request(CMD_QUERY,   32'h8000_0000, 0, 1'b0);
        add_request(CMD_REMOVE,  32'h0000_0000, 0, 1'b0);
        add_request(CMD_REMOVE,  32'h7FFF_FFFF, 0, 1'b0);
        add_request(CMD_QUERY,   32'h5555_AAAA, 0, 1'b0);

        // Random phases; the first one fills the table past capacity.
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            kind      = (random_count == 0) ? PH_FILL : t_phase'($urandom_range(0, 2));
            phase_len = (random_count == 0) ? 160 : $urandom_range(40, 120);
            calm      = ($urandom_range(0, 3) == 0);
            drain     = (random_count == 0) || ($urandom_range(0, 2) == 0);
            for (int n = 0; n < phase_len; n++) begin
                r = $urandom_range(0, 99);
                case (kind)
                    PH_FILL:  cmd = (r < 80) ? CMD_INSERT : (r < 85) ? CMD_REMOVE : CMD_QUERY;
                    PH_DRAIN: cmd = (r < 10) ? CMD_INSERT : (r < 80) ? CMD_REMOVE : CMD_QUERY;
                    default:  cmd = (r < 35) ? CMD_INSERT : (r < 65) ? CMD_REMOVE : CMD_QUERY;
                endcase
                if (cmd == CMD_QUERY) begin
                    if ($urandom_range(0, 4) == 0) cmd = CMD_UNUSED;
                    add_request(cmd, pick_query_value(), pick_gap(calm), drain && n == 0);
                end else begin
                    add_request(cmd, pick_key(), pick_gap(calm), drain && n == 0);
                end
                random_count++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (LG + 6) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
